>>> hw/rtl/iff_pkg.sv
`default_nettype none
package iff_pkg;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_FIELD_DEF = 64;
	localparam int VAL_BITS = 32;
	localparam int FW_BITS = 7;
	localparam int RADIX_BITS = 5;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_X_LO = 8'h78;

	typedef struct packed {
		logic [VAL_BITS-1:0] value_bits;
		logic signed_mode;
		logic [RADIX_BITS-1:0] radix;
		logic [FW_BITS-1:0] field_width;
		logic alternate_form;
		logic zero_pad;
		logic left_justify;
		logic space_sign;
		logic plus_sign;
		logic lower_case;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic last_char;
	} out_item_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
		logic [7:0] c;
		if (d < 4'd10) c = CH_ZERO + {4'd0, d};
		else if (lower) c = 8'h61 + {4'd0, d} - 8'd10;
		else c = 8'h41 + {4'd0, d} - 8'd10;
		return c;
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/iff_front.sv
`default_nettype none
// classifies an item: drops bad radix, takes magnitude, picks sign
module iff_front #(
	parameter int VALUE_WIDTH = iff_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_FIELD = iff_pkg::MAX_FIELD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire iff_pkg::in_item_t in_item,
	output logic q_valid,
	input wire logic q_take,
	output logic [VALUE_WIDTH-1:0] q_mag,
	output logic [7:0] q_sign,
	output logic q_has_sign,
	output logic [4:0] q_radix,
	output logic [7:0] q_width,
	output logic q_alt,
	output logic q_zpad,
	output logic q_left,
	output logic q_lower
);
	import iff_pkg::*;
	localparam int DEPTH = 2;
	logic [VALUE_WIDTH-1:0] mag_q [DEPTH];
	logic [7:0] sign_q [DEPTH];
	logic hs_q [DEPTH];
	logic [4:0] rad_q [DEPTH];
	logic [7:0] wid_q [DEPTH];
	logic [3:0] fl_q [DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic acc, good, neg;
	logic [VALUE_WIDTH-1:0] raw;
	logic [7:0] w8;

	assign full = (cnt_q == 2'd2);
	assign acc = push && !full;
	assign good = (in_item.radix >= 5'd2) && (in_item.radix <= 5'd16);
	assign raw = VALUE_WIDTH'(in_item.value_bits);
	assign neg = in_item.signed_mode && raw[VALUE_WIDTH-1];
	assign w8 = ({1'b0, in_item.field_width} > 8'(MAX_FIELD)) ? 8'(MAX_FIELD)
		: {1'b0, in_item.field_width};
	assign q_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc && good) wp_q <= !wp_q;
			if (q_take && q_valid) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(acc && good) - 2'(q_take && q_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && good) begin
			mag_q[wp_q] <= neg ? (~raw + 1'b1) : raw;
			sign_q[wp_q] <= neg ? CH_MINUS : (in_item.plus_sign ? CH_PLUS : CH_SPACE);
			hs_q[wp_q] <= neg || in_item.plus_sign || in_item.space_sign;
			rad_q[wp_q] <= in_item.radix;
			wid_q[wp_q] <= w8;
			fl_q[wp_q] <= {in_item.alternate_form && (in_item.radix == 5'd8
				|| in_item.radix == 5'd16),
				in_item.zero_pad && !in_item.left_justify,
				in_item.left_justify, in_item.lower_case};
		end
	end

	assign q_mag = mag_q[rp_q];
	assign q_sign = sign_q[rp_q];
	assign q_has_sign = hs_q[rp_q];
	assign q_radix = rad_q[rp_q];
	assign q_width = wid_q[rp_q];
	assign {q_alt, q_zpad, q_left, q_lower} = fl_q[rp_q];
endmodule
`default_nettype wire

>>> hw/rtl/iff_back.sv
`default_nettype none
// digit extraction by restoring division, then character sequencer
module iff_back #(
	parameter int VALUE_WIDTH = iff_pkg::VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_take,
	input wire logic [VALUE_WIDTH-1:0] q_mag,
	input wire logic [7:0] q_sign,
	input wire logic q_has_sign,
	input wire logic [4:0] q_radix,
	input wire logic [7:0] q_width,
	input wire logic q_alt,
	input wire logic q_zpad,
	input wire logic q_left,
	input wire logic q_lower,
	output logic empty,
	input wire logic pop,
	output iff_pkg::out_item_t out_item
);
	import iff_pkg::*;
	localparam int CW = $clog2(VALUE_WIDTH);
	localparam int DW = $clog2(VALUE_WIDTH + 1);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001, ST_DIV = 4'b0010, ST_EMIT = 4'b0100, ST_NEXT = 4'b1000
	} st_t;
	typedef enum logic [6:0] {
		PH_PAD = 7'b0000001, PH_SIGN = 7'b0000010, PH_P0 = 7'b0000100,
		PH_PX = 7'b0001000, PH_ZERO = 7'b0010000, PH_DIG = 7'b0100000,
		PH_RPAD = 7'b1000000
	} ph_t;
	st_t st_q;
	ph_t ph_q;
	logic [VALUE_WIDTH-1:0] quo_q, dvd_q;
	logic [4:0] rem_q;
	logic [CW-1:0] bit_q;
	logic [3:0] dig_q [VALUE_WIDTH];
	logic [DW-1:0] nd_q, di_q;
	logic [7:0] pad_q, pc_q, rad_q;
	logic hs_q, alt_q, hex_q, zp_q, lf_q, lo_q;
	logic [7:0] sgn_q, wid_q;
	logic ov_q;
	logic [7:0] ch_q;
	logic last_q;
	logic [5:0] trial;
	logic [7:0] used;
	logic [DW-1:0] ndn;
	logic [7:0] ch;
	logic is_last;
	logic ld;
	ph_t nph;

	assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign q_take = (st_q == ST_IDLE) && q_valid;
	assign empty = !ov_q;
	assign out_item = '{out_char: ch_q, last_char: last_q};
	assign ndn = nd_q + 1'b1;
	assign used = 8'(ndn) + 8'(hs_q) + 8'(alt_q) + 8'(alt_q && hex_q);
	assign ld = (st_q == ST_EMIT) && (!ov_q || pop);

	always_comb begin
		ch = CH_SPACE;
		nph = ph_q;
		is_last = 1'b0;
		unique case (ph_q)
			PH_PAD: begin
				ch = CH_SPACE;
				if (pc_q + 8'd1 >= pad_q) nph = PH_SIGN;
			end
			PH_SIGN: begin
				ch = sgn_q;
				nph = PH_P0;
			end
			PH_P0: begin
				ch = CH_ZERO;
				nph = PH_PX;
			end
			PH_PX: begin
				ch = lo_q ? CH_X_LO : CH_X_UP;
				nph = PH_ZERO;
			end
			PH_ZERO: begin
				ch = CH_ZERO;
				if (pc_q + 8'd1 >= pad_q) nph = PH_DIG;
			end
			PH_DIG: begin
				ch = digit_char(dig_q[di_q[CW-1:0]], lo_q);
				if (di_q == '0) begin
					nph = PH_RPAD;
					is_last = !(lf_q && pad_q != 8'd0);
				end
			end
			PH_RPAD: begin
				ch = CH_SPACE;
				is_last = (pc_q + 8'd1 >= pad_q);
			end
			default: ch = CH_SPACE;
		endcase
	end

	// skip empty phases
	function automatic ph_t skip(input ph_t p, input logic [7:0] pad, input logic hs,
		input logic alt, input logic hex, input logic zp, input logic lf);
		ph_t r;
		r = p;
		if (r == PH_PAD && (pad == 8'd0 || zp || lf)) r = PH_SIGN;
		if (r == PH_SIGN && !hs) r = PH_P0;
		if (r == PH_P0 && !alt) r = PH_PX;
		if (r == PH_PX && !(alt && hex)) r = PH_ZERO;
		if (r == PH_ZERO && (pad == 8'd0 || !zp)) r = PH_DIG;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
			ph_q <= PH_PAD;
		end else begin
			if (ld) ov_q <= 1'b1;
			else if (pop && ov_q) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid) st_q <= ST_DIV;
				ST_DIV: if (bit_q == '0) st_q <= ST_NEXT;
				ST_NEXT: begin
					if (quo_q == '0) begin
						st_q <= ST_EMIT;
						ph_q <= skip(PH_PAD, (wid_q > used) ? wid_q - used : 8'd0,
							hs_q, alt_q, hex_q, zp_q, lf_q);
					end else st_q <= ST_DIV;
				end
				ST_EMIT: if (ld) begin
					if (is_last) st_q <= ST_IDLE;
					else if (nph != ph_q)
						ph_q <= skip(nph, pad_q, hs_q, alt_q, hex_q, zp_q, lf_q);
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				dvd_q <= q_mag;
				rem_q <= '0;
				bit_q <= CW'(VALUE_WIDTH - 1);
				nd_q <= '0;
				rad_q <= {3'd0, q_radix};
				sgn_q <= q_sign;
				hs_q <= q_has_sign;
				wid_q <= q_width;
				alt_q <= q_alt;
				hex_q <= (q_radix == 5'd16);
				zp_q <= q_zpad;
				lf_q <= q_left;
				lo_q <= q_lower;
			end
			ST_DIV: begin
				// one quotient bit per cycle
				if ({2'b0, trial} >= rad_q) begin
					rem_q <= 5'(trial - rad_q[5:0]);
					quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
				end else begin
					rem_q <= trial[4:0];
					quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
				end
				dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
				bit_q <= bit_q - 1'b1;
			end
			ST_NEXT: begin
				dig_q[nd_q[CW-1:0]] <= rem_q[3:0];
				if (quo_q == '0) begin
					di_q <= nd_q;
					pad_q <= (wid_q > used) ? wid_q - used : 8'd0;
					pc_q <= '0;
				end else begin
					nd_q <= ndn;
					dvd_q <= quo_q;
					rem_q <= '0;
					bit_q <= CW'(VALUE_WIDTH - 1);
				end
			end
			ST_EMIT: if (ld) begin
				ch_q <= ch;
				last_q <= is_last;
				if (ph_q == PH_DIG) di_q <= di_q - 1'b1;
				if (nph != ph_q) pc_q <= '0;
				else pc_q <= pc_q + 8'd1;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> hw/rtl/integer_field_formatter.sv
// channel  | handshake        | payload
// request  | push / full      | in_item  (iff_pkg::in_item_t)
// result   | pop / empty      | out_item (iff_pkg::out_item_t)
// each value: taken from the queue, then one digit at a time through the
// shared restoring divider, then one character per cycle while results are taken
// reset clears queue pointers, sequencer and output valid; no clearing pass
// a two-entry queue lets requests enter while the back end divides or stalls
// a bad radix is dropped at the front and produces nothing
`default_nettype none
module integer_field_formatter #(
	parameter int VALUE_WIDTH = iff_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_FIELD = iff_pkg::MAX_FIELD_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire iff_pkg::in_item_t in_item,
	output logic empty,
	input wire logic pop,
	output iff_pkg::out_item_t out_item
);
	import iff_pkg::*;
	logic q_valid, q_take, q_has_sign, q_alt, q_zpad, q_left, q_lower;
	logic [VALUE_WIDTH-1:0] q_mag;
	logic [7:0] q_sign, q_width;
	logic [4:0] q_radix;

	// front: classify and queue
	iff_front #(.VALUE_WIDTH(VALUE_WIDTH), .MAX_FIELD(MAX_FIELD)) u_front (
		.clk, .arst_n, .push, .full, .in_item, .q_valid, .q_take, .q_mag, .q_sign,
		.q_has_sign, .q_radix, .q_width, .q_alt, .q_zpad, .q_left, .q_lower);

	// back: digits and characters
	iff_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_mag, .q_sign, .q_has_sign, .q_radix,
		.q_width, .q_alt, .q_zpad, .q_left, .q_lower, .empty, .pop, .out_item);
endmodule
`default_nettype wire

>>> hw/rtl/iff_checker.sv
`default_nettype none
module iff_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic full,
	input wire logic empty,
	input wire logic pop,
	input wire iff_pkg::out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item)) else $error("result dropped");
	a_rst: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("reset state");
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.out_char >= 8'h20) else $error("bad char");
endmodule
bind integer_field_formatter iff_checker u_chk (.clk, .arst_n, .full, .empty,
	.pop, .out_item);
`default_nettype wire
